// ----- sv/assert_macros.svh -----
// Assertion macros shared by the modular inverse unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- sv/mie_pkg.sv -----
// Types shared by the modular inverse unit
package mie_pkg;
   localparam int FieldWidth = 31;

   typedef struct packed {
      logic [FieldWidth-1:0] value;
      logic [FieldWidth-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [FieldWidth-1:0] inverse;
      logic                  exists;
   } rsp_type;

   typedef struct packed {
      logic load;     // take operands from the request
      logic div_start;
      logic div_step; // one quotient bit
      logic update;   // apply a Euclid step
      logic fix;      // reduce the coefficient into range
   } cmd_type;

   typedef struct packed {
      logic b_zero;
      logic div_last;
      logic limit;
   } sts_type;
endpackage

// ----- sv/mie_datapath.sv -----
// Datapath: restoring divider, remainder and coefficient registers
module mie_datapath #(
   parameter int StepLimit = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  mie_pkg::req_type  req_data,
   input  mie_pkg::cmd_type  cmd,
   output mie_pkg::sts_type  sts,
   output mie_pkg::rsp_type  result
);
   localparam int W  = mie_pkg::FieldWidth;
   localparam int CW = W + 2;
   localparam int SW = $clog2(StepLimit + 1);
   localparam int BW = $clog2(W);

   logic [W-1:0]    a_ff, a_in, b_ff, b_in, m_ff, m_in;
   logic [W-1:0]    q_ff, q_in, rem_ff, rem_in;
   logic signed [CW-1:0] c_ff, c_in, n_ff, n_in;
   logic [BW-1:0]   bit_ff, bit_in;
   logic [SW-1:0]   steps_ff, steps_in;
   logic [W:0]      trial;
   logic signed [CW+W:0] prod;
   logic signed [CW-1:0] t_val;

   assign trial = {rem_ff, a_ff[bit_ff]} - {1'b0, b_ff};
   assign prod  = $signed({1'b0, q_ff}) * n_ff;
   assign t_val = c_ff - prod[CW-1:0];

   always_comb begin
      a_in = a_ff; b_in = b_ff; m_in = m_ff; q_in = q_ff; rem_in = rem_ff;
      c_in = c_ff; n_in = n_ff; bit_in = bit_ff; steps_in = steps_ff;
      if (cmd.load) begin
         a_in = req_data.value; b_in = req_data.modulus; m_in = req_data.modulus;
         c_in = CW'(1); n_in = '0; steps_in = '0;
      end
      if (cmd.div_start) begin
         q_in = '0; rem_in = '0; bit_in = BW'(W - 1);
      end
      if (cmd.div_step) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], a_ff[bit_ff]};
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         bit_in = bit_ff - BW'(1);
      end
      if (cmd.update) begin
         a_in = b_ff; b_in = rem_ff; c_in = n_ff; n_in = t_val;
         steps_in = steps_ff + SW'(1);
      end
      if (cmd.fix) begin
         // |coef| <= m, so one correction suffices
         if (c_ff < 0) c_in = c_ff + $signed({2'b00, m_ff});
         else if (c_ff >= $signed({2'b00, m_ff})) c_in = c_ff - $signed({2'b00, m_ff});
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; m_ff <= m_in; q_ff <= q_in; rem_ff <= rem_in;
      c_ff <= c_in; n_ff <= n_in; bit_ff <= bit_in;
      if (reset) steps_ff <= '0;
      else steps_ff <= steps_in;
   end

   assign sts.b_zero   = (b_ff == '0);
   assign sts.div_last = (bit_ff == '0);
   assign sts.limit    = (steps_ff >= SW'(StepLimit));

   assign result.exists  = (m_ff != '0) && (b_ff == '0) && (a_ff == W'(1));
   assign result.inverse = result.exists ? c_ff[W-1:0] : '0;
endmodule

// ----- sv/mie_controller.sv -----
// Controller: sequences loads, divisions, updates and the result transfer
`include "assert_macros.svh"
module mie_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  mie_pkg::sts_type sts,
   output mie_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {IDLE, CHECK, DIVIDE, UPDATE, FIX, DONE} state_type;
   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: if (req_valid) begin
            cmd.load = 1'b1; state_in = CHECK;
         end
         CHECK: if (sts.b_zero || sts.limit) state_in = FIX;
                else begin cmd.div_start = 1'b1; state_in = DIVIDE; end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = UPDATE;
         end
         UPDATE: begin cmd.update = 1'b1; state_in = CHECK; end
         FIX: begin cmd.fix = 1'b1; state_in = DONE; end
         DONE: if (rsp_ready) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == DONE);

   `ASSERT_IMPL(a_excl, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_load, clock, reset, req_valid && req_ready, state_ff == CHECK)
endmodule

// ----- sv/modular_inverse_ext_euclid_unit.sv -----
// Modular inverse by the extended Euclidean algorithm
// Sequence: each Euclid step is a check, a bit-serial restoring division and an update;
//   a final fix reduces the coefficient into range, and the result is held until taken.
// Throughput: one item at a time; the shared bit-serial divider sets the rate.
// Reset: synchronous, active high; returns the controller to idle, no result pending.
module modular_inverse_ext_euclid_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mie_pkg::rsp_type rsp_data
);
   mie_pkg::cmd_type cmd;
   mie_pkg::sts_type sts;

   mie_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   mie_datapath #(.StepLimit(2 * DATA_WIDTH)) u_dp (
      .clock, .reset, .req_data, .cmd, .sts, .result(rsp_data)
   );
endmodule
